[rtl/core/wsfu_pkg.sv]
// Package: shared widths, codes and result type of the WebSocket frame unmasker.
`timescale 1ns / 1ps

package wsfu_pkg;

  localparam int unsigned COUNT_WIDTH_DEF = 16;
  localparam int unsigned BYTE_W          = 8;
  localparam int unsigned LEN_W           = 16;
  localparam int unsigned POS_W           = 4;
  localparam int unsigned KEY_BYTES       = 4;

  localparam logic [7:0]       OPCODE_MASK   = 8'h0F;
  localparam logic [7:0]       OPCODE_BINARY = 8'h02;
  localparam logic [7:0]       CLOSE_BYTE    = 8'd136;
  localparam logic [7:0]       LEN_CODE_MASK = 8'd127;
  localparam logic [6:0]       LEN_CODE_16   = 7'd126;
  localparam logic [6:0]       LEN_CODE_SHORT_MAX = 7'd125;
  localparam logic [POS_W-1:0] OFFSET_SHORT  = 4'd2;
  localparam logic [POS_W-1:0] OFFSET_16     = 4'd4;
  localparam logic [POS_W-1:0] OFFSET_64     = 4'd10;
  localparam logic [POS_W-1:0] KEY_LEN       = 4'd4;
  localparam logic [LEN_W-1:0] LEN_MAX       = 16'hFFFF;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_CLOSE       = 2'd1,
    ST_UNSUPPORTED = 2'd2,
    ST_TRUNCATED   = 2'd3
  } status_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              byte_valid;
    logic              frame_end;
    status_t           frame_status;
    logic [LEN_W-1:0]  payload_length;
  } result_t;

endpackage

[rtl/core/websocket_frame_unmasker_top.sv]
// Top level: WebSocket receive deframer that unmasks one binary frame's payload bytes.
// Each result is registered in out_r before it shows on out_*, passing through the skid entry when the output stalls.
// Throughput: one byte per cycle while in_tready is high; header and dropped bytes give a result only at frame end.
// Output register plus one skid entry: in_tready stays high while one result waits.
// Reset: synchronous, active-low rst_n clears frame state and both output entries.
// Every final byte rearms the frame state to its reset values.
`timescale 1ns / 1ps

module websocket_frame_unmasker_top #(
  parameter int unsigned COUNT_WIDTH = wsfu_pkg::COUNT_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: [7:0] rx_byte
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tlast,
  // out_tdata: [7:0] out_byte, [23:8] payload_length
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,
  output logic        out_tlast,
  // out_tuser: [0] byte_valid, [2:1] frame_status
  output logic [2:0]  out_tuser
);

  localparam int unsigned PW = wsfu_pkg::POS_W;
  localparam int unsigned BW = wsfu_pkg::BYTE_W;

  logic [PW-1:0]          pos_r, pos_nxt;
  logic [PW-1:0]          mask_off_r, mask_off_nxt;
  logic [BW-1:0]          key_r   [wsfu_pkg::KEY_BYTES];
  logic [BW-1:0]          key_nxt [wsfu_pkg::KEY_BYTES];
  logic [COUNT_WIDTH-1:0] cnt_r, cnt_nxt;
  wsfu_pkg::status_t      verdict_r, verdict_nxt;
  logic [1:0]             phase_r, phase_nxt;

  wsfu_pkg::result_t out_r, skid_r, res;
  logic              out_valid_r, skid_valid_r, res_valid;

  logic              accept;
  logic [PW-1:0]     data_start;
  logic [PW-1:0]     key_rel;
  logic              payload;
  logic [6:0]        len_code;
  wsfu_pkg::status_t end_st;

  assign in_tready = !skid_valid_r;
  assign accept    = in_tvalid && in_tready;

  assign data_start = mask_off_r + wsfu_pkg::KEY_LEN;
  assign key_rel    = pos_r - mask_off_r;
  assign len_code   = 7'(in_tdata & wsfu_pkg::LEN_CODE_MASK);

  always_comb begin
    pos_nxt      = pos_r;
    mask_off_nxt = mask_off_r;
    key_nxt      = key_r;
    cnt_nxt      = cnt_r;
    verdict_nxt  = verdict_r;
    phase_nxt    = phase_r;
    payload      = 1'b0;
    res_valid    = 1'b0;
    res          = '0;
    end_st       = wsfu_pkg::ST_OK;
    if (accept) begin
      if (pos_r == '0) begin
        if ((in_tdata & wsfu_pkg::OPCODE_MASK) == wsfu_pkg::OPCODE_BINARY) begin
          verdict_nxt = wsfu_pkg::ST_OK;
        end else if (in_tdata == wsfu_pkg::CLOSE_BYTE) begin
          verdict_nxt = wsfu_pkg::ST_CLOSE;
        end else begin
          verdict_nxt = wsfu_pkg::ST_UNSUPPORTED;
        end
        pos_nxt = PW'(1);
      end else if (verdict_r != wsfu_pkg::ST_OK) begin
        // drop the rest of a rejected frame
      end else if (pos_r == PW'(1)) begin
        if (len_code <= wsfu_pkg::LEN_CODE_SHORT_MAX) begin
          mask_off_nxt = wsfu_pkg::OFFSET_SHORT;
        end else if (len_code == wsfu_pkg::LEN_CODE_16) begin
          mask_off_nxt = wsfu_pkg::OFFSET_16;
        end else begin
          mask_off_nxt = wsfu_pkg::OFFSET_64;
        end
        pos_nxt = PW'(2);
      end else if (pos_r < data_start) begin
        if (pos_r >= mask_off_r) begin
          key_nxt[key_rel[1:0]] = in_tdata;
        end
        pos_nxt = pos_r + PW'(1);
      end else begin
        payload   = 1'b1;
        phase_nxt = phase_r + 2'd1;
        if (cnt_r != '1) begin
          cnt_nxt = cnt_r + COUNT_WIDTH'(1);
        end
        res_valid      = 1'b1;
        res.out_byte   = in_tdata ^ key_r[phase_r];
        res.byte_valid = 1'b1;
        res.frame_end  = in_tlast;
        res.frame_status = wsfu_pkg::ST_OK;
      end

      if (!payload && in_tlast) begin
        end_st = verdict_nxt;
        if (end_st == wsfu_pkg::ST_OK && pos_nxt < (mask_off_nxt + wsfu_pkg::KEY_LEN)) begin
          end_st = wsfu_pkg::ST_TRUNCATED;
        end
        res_valid        = 1'b1;
        res.frame_end    = 1'b1;
        res.frame_status = end_st;
      end

      if (64'(cnt_nxt) > 64'(wsfu_pkg::LEN_MAX)) begin
        res.payload_length = wsfu_pkg::LEN_MAX;
      end else begin
        res.payload_length = wsfu_pkg::LEN_W'(cnt_nxt);
      end

      if (in_tlast) begin
        pos_nxt      = '0;
        mask_off_nxt = wsfu_pkg::OFFSET_SHORT;
        key_nxt      = '{default: '0};
        cnt_nxt      = '0;
        verdict_nxt  = wsfu_pkg::ST_OK;
        phase_nxt    = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= '0;
      mask_off_r   <= wsfu_pkg::OFFSET_SHORT;
      key_r        <= '{default: '0};
      cnt_r        <= '0;
      verdict_r    <= wsfu_pkg::ST_OK;
      phase_r      <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      pos_r      <= pos_nxt;
      mask_off_r <= mask_off_nxt;
      key_r      <= key_nxt;
      cnt_r      <= cnt_nxt;
      verdict_r  <= verdict_nxt;
      phase_r    <= phase_nxt;
      if (!out_valid_r || out_tready) begin
        if (skid_valid_r) begin
          out_valid_r  <= 1'b1;
          skid_valid_r <= 1'b0;
        end else begin
          out_valid_r <= res_valid;
        end
      end else if (res_valid) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_tready) begin
      if (skid_valid_r) begin
        out_r <= skid_r;
      end else begin
        out_r <= res;
      end
    end else if (res_valid) begin
      skid_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_r.payload_length, out_r.out_byte};
  assign out_tlast  = out_r.frame_end;
  assign out_tuser  = {out_r.frame_status, out_r.byte_valid};

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held without a waiting output");

  a_payload_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tuser[2:1] == wsfu_pkg::ST_OK)
    else $error("payload byte reported with a non-ok status");

  a_status_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tlast)
    else $error("result without payload byte outside frame end");

  a_pos_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= data_start)
    else $error("header position beyond start of payload");

  a_offset_legal: assert property (@(posedge clk) disable iff (!rst_n)
    mask_off_r == wsfu_pkg::OFFSET_SHORT || mask_off_r == wsfu_pkg::OFFSET_16 ||
    mask_off_r == wsfu_pkg::OFFSET_64)
    else $error("mask offset outside the three header layouts");

  a_stall_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r && out_tvalid && !out_tready |=> skid_valid_r)
    else $error("skid entry lost while output stalled");

endmodule

[sim/websocket_frame_unmasker_check.sv]
// Checker: predicts the unmasker's results from accepted requests and compares them.
`timescale 1ns / 1ps

module websocket_frame_unmasker_check (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,
  input  logic        out_tlast,
  input  logic [2:0]  out_tuser,
  output int          fail_count,
  output int          pending,
  output int          frames_seen,
  output int          payload_seen,
  output int          longest_seen
);

  logic [wsfu_pkg::POS_W-1:0]  hdr_pos;
  logic [wsfu_pkg::POS_W-1:0]  key_off;
  logic [wsfu_pkg::BYTE_W-1:0] mask_key [wsfu_pkg::KEY_BYTES];
  logic [wsfu_pkg::LEN_W-1:0]  unmasked_count;
  logic [1:0]                  key_phase;
  wsfu_pkg::status_t           verdict;
  wsfu_pkg::result_t           due_results [$];

  task automatic rearm_frame();
    hdr_pos = '0;
    key_off = wsfu_pkg::OFFSET_SHORT;
    foreach (mask_key[i]) mask_key[i] = '0;
    unmasked_count = '0;
    key_phase = '0;
    verdict = wsfu_pkg::ST_OK;
  endtask

  task automatic unmask_request(input logic [7:0] b, input logic last);
    wsfu_pkg::result_t r;
    logic [wsfu_pkg::POS_W-1:0] rel;
    r = '0;
    rel = hdr_pos - key_off;
    if (hdr_pos == '0) begin
      if ((b & wsfu_pkg::OPCODE_MASK) == wsfu_pkg::OPCODE_BINARY) begin
        verdict = wsfu_pkg::ST_OK;
      end else if (b == wsfu_pkg::CLOSE_BYTE) begin
        verdict = wsfu_pkg::ST_CLOSE;
      end else begin
        verdict = wsfu_pkg::ST_UNSUPPORTED;
      end
      hdr_pos = 4'd1;
    end else if (verdict == wsfu_pkg::ST_OK) begin
      if (hdr_pos == 4'd1) begin
        if (b[6:0] <= wsfu_pkg::LEN_CODE_SHORT_MAX) begin
          key_off = wsfu_pkg::OFFSET_SHORT;
        end else if (b[6:0] == wsfu_pkg::LEN_CODE_16) begin
          key_off = wsfu_pkg::OFFSET_16;
        end else begin
          key_off = wsfu_pkg::OFFSET_64;
        end
        hdr_pos = 4'd2;
      end else if (hdr_pos < key_off + wsfu_pkg::KEY_LEN) begin
        if (hdr_pos >= key_off) mask_key[rel[1:0]] = b;
        hdr_pos = hdr_pos + 4'd1;
      end else begin
        r.out_byte = b ^ mask_key[key_phase];
        key_phase = key_phase + 2'd1;
        if (unmasked_count != wsfu_pkg::LEN_MAX) unmasked_count = unmasked_count + 1'b1;
        r.byte_valid = 1'b1;
        r.frame_end = last;
        r.frame_status = wsfu_pkg::ST_OK;
        r.payload_length = unmasked_count;
        due_results.push_back(r);
        if (last) rearm_frame();
        return;
      end
    end
    if (last) begin
      r.frame_end = 1'b1;
      r.frame_status = verdict;
      if (verdict == wsfu_pkg::ST_OK && hdr_pos < key_off + wsfu_pkg::KEY_LEN) begin
        r.frame_status = wsfu_pkg::ST_TRUNCATED;
      end
      r.payload_length = unmasked_count;
      due_results.push_back(r);
      rearm_frame();
    end
  endtask

  always @(posedge clk) begin
    wsfu_pkg::result_t got;
    wsfu_pkg::result_t want;
    if (!rst_n) begin
      rearm_frame();
      due_results.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got.out_byte = out_tdata[7:0];
        got.payload_length = out_tdata[23:8];
        got.byte_valid = out_tuser[0];
        got.frame_status = wsfu_pkg::status_t'(out_tuser[2:1]);
        got.frame_end = out_tlast;
        if (due_results.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result, byte %02h valid %b end %b status %0d length %0d",
                   $time, got.out_byte, got.byte_valid, got.frame_end, got.frame_status,
                   got.payload_length);
        end else begin
          want = due_results.pop_front();
          if (got !== want) begin
            fail_count++;
            $display("%0t: mismatch, expected %02h %b %b %0d %0d, got %02h %b %b %0d %0d",
                     $time, want.out_byte, want.byte_valid, want.frame_end, want.frame_status,
                     want.payload_length, got.out_byte, got.byte_valid, got.frame_end,
                     got.frame_status, got.payload_length);
          end
        end
        if (got.frame_end) frames_seen++;
        if (got.byte_valid) payload_seen++;
        if (int'(got.payload_length) > longest_seen) longest_seen = int'(got.payload_length);
      end
      if (in_tvalid && in_tready) unmask_request(in_tdata, in_tlast);
    end
    pending = due_results.size();
  end

endmodule

[sim/websocket_frame_unmasker_top_test.sv]
// Testbench top: drives frames into the unmasker, paces the result side and gives the verdict.
`timescale 1ns / 1ps

module websocket_frame_unmasker_top_test;

  localparam int RANDOM_ITEMS = 1350;
  localparam int HOLD_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 1000000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;
  logic        out_tlast;
  logic [2:0]  out_tuser;

  int fail_count;
  int pending;
  int frames_seen;
  int payload_seen;
  int longest_seen;
  int random_items;
  int cycle_count;
  bit hold_off;
  bit no_gaps;

  websocket_frame_unmasker_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  websocket_frame_unmasker_check chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tlast     (in_tlast),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tlast    (out_tlast),
    .out_tuser    (out_tuser),
    .fail_count   (fail_count),
    .pending      (pending),
    .frames_seen  (frames_seen),
    .payload_seen (payload_seen),
    .longest_seen (longest_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 8);
    repeat (gap) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
  endtask

  // cut: 0 sends the whole frame, > 0 at most that many bytes, < 0 ends it inside the header
  task automatic send_frame(input logic [7:0] op, input logic [7:0] len_byte, input int n_pay,
                            input int cut);
    logic [7:0] fb [$];
    int ext;
    int n;
    ext = (len_byte[6:0] == wsfu_pkg::LEN_CODE_16) ? 2 :
          (len_byte[6:0] > wsfu_pkg::LEN_CODE_16) ? 8 : 0;
    fb.push_back(op);
    fb.push_back(len_byte);
    repeat (ext + int'(wsfu_pkg::KEY_LEN) + n_pay) fb.push_back(8'($urandom_range(0, 255)));
    n = fb.size();
    if (cut < 0) begin
      n = $urandom_range(1, ext + 5);
    end else if (cut > 0 && cut < n) begin
      n = cut;
    end
    for (int i = 0; i < n; i++) send_byte(fb[i], i == n - 1);
    random_items += n;
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    wait (pending == 0);
  endtask

  initial begin : receiver
    int stall;
    bit held;
    held = 1'b0;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_off && !held) begin
        repeat (HOLD_CYCLES) begin
          @(negedge clk);
          out_tready <= 1'b0;
        end
        held = 1'b1;
      end else if (!hold_off) begin
        held = 1'b0;
      end
      stall = no_gaps ? 0 : $urandom_range(0, 8);
      repeat (stall) begin
        @(negedge clk);
        out_tready <= 1'b0;
      end
      @(negedge clk);
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: run stopped after %0d cycles", $time, cycle_count);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    int pick;
    int lsel;
    logic [7:0] op;
    logic [7:0] len_byte;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    hold_off = 1'b0;
    no_gaps = 1'b0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    send_frame(8'h82, 8'h00, 0, 1);
    send_frame(wsfu_pkg::CLOSE_BYTE, 8'h00, 0, 1);
    send_frame(8'h01, 8'hFF, 0, 3);
    send_frame(8'h08, 8'h00, 0, 2);
    send_frame(8'hF2, 8'h00, 0, 0);
    send_frame(8'h02, {1'b1, wsfu_pkg::LEN_CODE_SHORT_MAX}, 3, 0);
    send_frame(8'h82, {1'b1, wsfu_pkg::LEN_CODE_16}, 0, 5);
    drain_results();

    // hold the result side while requests keep coming
    hold_off = 1'b1;
    no_gaps = 1'b1;
    send_frame(8'h82, {1'b1, wsfu_pkg::LEN_CODE_16}, 48, 0);
    no_gaps = 1'b0;
    hold_off = 1'b0;
    drain_results();

    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      no_gaps = (random_items >= 500 && random_items < 700);
      pick = $urandom_range(0, 99);
      lsel = $urandom_range(0, 9);
      len_byte[7] = 1'($urandom_range(0, 1));
      if (lsel < 6) begin
        len_byte[6:0] = 7'($urandom_range(0, 125));
      end else if (lsel < 8) begin
        len_byte[6:0] = wsfu_pkg::LEN_CODE_16;
      end else begin
        len_byte[6:0] = 7'd127;
      end
      if (pick < 8) begin
        op = 8'($urandom_range(0, 255));
        if (op[3:0] == wsfu_pkg::OPCODE_BINARY[3:0] || pick < 3) op = wsfu_pkg::CLOSE_BYTE;
        send_frame(op, len_byte, $urandom_range(0, 6), 0);
      end else if (pick < 18) begin
        send_frame({4'($urandom_range(0, 15)), wsfu_pkg::OPCODE_BINARY[3:0]}, len_byte, 0, -1);
      end else begin
        send_frame({4'($urandom_range(0, 15)), wsfu_pkg::OPCODE_BINARY[3:0]}, len_byte,
                   pick < 24 ? 0 : pick < 85 ? $urandom_range(1, 12) : $urandom_range(13, 64),
                   0);
      end
    end
    no_gaps = 1'b0;
    drain_results();
    repeat (4) @(posedge clk);

    $display("Checked %0d frames of every status with %0d unmasked payload bytes,",
             frames_seen, payload_seen);
    $display("including stalls on both sides; longest payload count %0d.", longest_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/wsfu_pkg.sv
rtl/core/websocket_frame_unmasker_top.sv
sim/websocket_frame_unmasker_check.sv
sim/websocket_frame_unmasker_top_test.sv
